FILE: src/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// Shared constants and types for the increasing-subsequence length tracker.
// ----------------------------------------------------------------------------
package lis_pkg;

  // Number of tail-table entries. This is also the longest sequence that is tracked.
  localparam int DEPTH       = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int OUT_W       = 11;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [CNT_W-1:0]       count_t;

  // Ports of the tail-table memory, driven by the controller.
  typedef struct packed {
    logic   we;
    addr_t  waddr;
    value_t wdata;
    addr_t  raddr;
  } mem_req_t;

  // One finished result.
  typedef struct packed {
    logic [OUT_W-1:0] lis_length;
    logic [OUT_W-1:0] change_count;
    logic             sequence_end;
    logic             overflow;
  } result_t;

endpackage

FILE: src/lis_tail_ram.sv
// ----------------------------------------------------------------------------
// lis_tail_ram
// Tail table: one write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module lis_tail_ram (
  input  logic               clk,
  input  lis_pkg::mem_req_t  req,
  output lis_pkg::value_t    rd_data
);

  lis_pkg::value_t mem [lis_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

FILE: src/lis_search.sv
// ----------------------------------------------------------------------------
// lis_search
// Sequencer: append test, binary search over the tail table, and the
// length and item-count registers.
// ----------------------------------------------------------------------------
module lis_search (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lis_pkg::value_t    in_value,
  input  logic               in_last,
  output logic               res_valid,
  input  logic               res_ready,
  output lis_pkg::result_t   res,
  output lis_pkg::mem_req_t  mem_req,
  input  lis_pkg::value_t    rd_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_TOP   = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state, state_next;
  lis_pkg::count_t  len, len_next;
  lis_pkg::count_t  cnt, cnt_next;
  lis_pkg::addr_t   lo, lo_next;
  lis_pkg::addr_t   hi, hi_next;
  lis_pkg::value_t  key, key_next;
  logic             last, last_next;
  logic             over, over_next;

  logic [lis_pkg::ADDR_W:0] mid_sum;
  lis_pkg::addr_t           mid;
  lis_pkg::addr_t           probe_lo;
  lis_pkg::addr_t           probe_hi;
  logic [lis_pkg::ADDR_W:0] next_sum;
  logic                     tail_less;

  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid       = mid_sum[lis_pkg::ADDR_W:1];
  assign tail_less = $signed(rd_data) < $signed(key);

  // Narrowing of the search window after one probe.
  always_comb begin
    if (tail_less) begin
      probe_lo = mid + lis_pkg::ADDR_W'(1);
      probe_hi = hi;
    end else begin
      probe_lo = lo;
      probe_hi = mid;
    end
    next_sum = {1'b0, probe_lo} + {1'b0, probe_hi};
  end

  always_comb begin
    state_next = state;
    len_next   = len;
    cnt_next   = cnt;
    lo_next    = lo;
    hi_next    = hi;
    key_next   = key;
    last_next  = last;
    over_next  = over;
    mem_req    = '0;
    case (state)
      S_IDLE: begin
        mem_req.raddr = lis_pkg::ADDR_W'(len - lis_pkg::CNT_W'(1));
        if (in_valid) begin
          key_next  = in_value;
          last_next = in_last;
          over_next = 1'b0;
          if (cnt == lis_pkg::CNT_W'(lis_pkg::DEPTH)) begin
            over_next  = 1'b1;
            state_next = S_DONE;
          end else if (len == '0) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = '0;
            mem_req.wdata = in_value;
            len_next      = lis_pkg::CNT_W'(1);
            cnt_next      = cnt + lis_pkg::CNT_W'(1);
            state_next    = S_DONE;
          end else begin
            state_next = S_TOP;
          end
        end
      end
      S_TOP: begin
        // rd_data holds the last kept tail.
        mem_req.wdata = key;
        if (tail_less) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = len[lis_pkg::ADDR_W-1:0];
          len_next      = len + lis_pkg::CNT_W'(1);
          cnt_next      = cnt + lis_pkg::CNT_W'(1);
          state_next    = S_DONE;
        end else if (len == lis_pkg::CNT_W'(1)) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = '0;
          cnt_next      = cnt + lis_pkg::CNT_W'(1);
          state_next    = S_DONE;
        end else begin
          lo_next       = '0;
          hi_next       = lis_pkg::ADDR_W'(len - lis_pkg::CNT_W'(1));
          mem_req.raddr = hi_next >> 1;
          state_next    = S_PROBE;
        end
      end
      S_PROBE: begin
        // rd_data holds the tail at mid.
        mem_req.wdata = key;
        lo_next       = probe_lo;
        hi_next       = probe_hi;
        mem_req.raddr = next_sum[lis_pkg::ADDR_W:1];
        if (probe_lo == probe_hi) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = probe_lo;
          cnt_next      = cnt + lis_pkg::CNT_W'(1);
          state_next    = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          if (last) begin
            len_next = '0;
            cnt_next = '0;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      len   <= len_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    lo   <= lo_next;
    hi   <= hi_next;
    key  <= key_next;
    last <= last_next;
    over <= over_next;
  end

  assign in_ready             = (state == S_IDLE);
  assign res_valid            = (state == S_DONE);
  assign res.lis_length       = lis_pkg::OUT_W'(len);
  assign res.change_count     = lis_pkg::OUT_W'(cnt - len);
  assign res.sequence_end     = last;
  assign res.overflow         = over;

  // The subsequence can never be longer than the items that built it.
  a_len_le_cnt: assert property (@(posedge clk) disable iff (rst) len <= cnt)
    else $error("table length exceeds item count");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= lis_pkg::CNT_W'(lis_pkg::DEPTH))
    else $error("item count beyond table depth");

  // A probe always has an open search window.
  a_probe_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (lo < hi))
    else $error("binary search window collapsed before probe");

  // An overflowed item must leave the table untouched.
  a_over_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && over) |-> $stable(len) || $past(state == S_DONE))
    else $error("state changed on an overflowed item");

endmodule

FILE: src/lis_length_tracker_core.sv
// ----------------------------------------------------------------------------
// lis_length_tracker_core
// Running length of the longest strictly increasing subsequence of a stream
// of signed values, kept by patience sorting over a tail table in RAM.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | tdata                         | tlast        | tuser
//  ---------+-----------+-------------------------------+--------------+---------
//  s_axis   | in        | value[31:0]                   | last_item    | -
//  m_axis   | out       | lis_length[10:0],             | sequence_end | overflow
//           |           | change_count[21:11], 0[23:22] |              |
//
// Steps: an item that overflows or starts a sequence goes straight to its
// result; an item that extends the table goes through the append test
// first; an item that replaces a tail then runs a binary search over the
// table, one read of the single read port of the tail-table RAM per step,
// with registered read data.
// Reset (rst, synchronous) clears the length, the item count and the
// handshake state; the tail table is not cleared, since only entries
// written in the current sequence are ever read.
// A result waits in the output register while the next transaction is
// already accepted; a stall on m_axis holds the sequencer in its final
// state once a second result is ready.
//
module lis_length_tracker_core (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic        s_axis_tlast,   // last_item
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [10:0] lis_length, [21:11] change_count
  output logic        m_axis_tlast,   // sequence_end
  output logic        m_axis_tuser    // overflow
);

  lis_pkg::mem_req_t mem_req;
  lis_pkg::value_t   rd_data;
  lis_pkg::result_t  res;
  logic              res_valid;
  logic              res_ready;

  // The sequencer owns the tail table and runs the search for one item at a
  // time, so a table write and a later read of the same entry never overlap.
  lis_search u_search (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_value  (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  lis_tail_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Output register: it takes a new result whenever it is empty or its
  // current transaction completes in this cycle.
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {2'b00, res.change_count, res.lis_length};
      m_axis_tlast <= res.sequence_end;
      m_axis_tuser <= res.overflow;
    end
  end

  // A result is loaded only into a free register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("pending result dropped");

  // The change count never exceeds the number of items in a sequence.
  a_change_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[21:11] <= 11'(lis_pkg::DEPTH)))
    else $error("change count out of range");

  // Overflow results report an unchanged, full item count.
  a_over_full: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      ((m_axis_tdata[10:0] + m_axis_tdata[21:11]) == 11'(lis_pkg::DEPTH)))
    else $error("overflow reported below full item count");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lis_length_tracker_core. Signed values go in as
// sequences closed by tlast. A patience-sort tail table kept in the bench
// predicts, for every value, the running subsequence length, the change
// count, the end flag and the overflow flag. Each result is checked against
// the oldest prediction. The run covers directed extremes, a full-depth
// sequence with overflow and random sequences under changing stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic signed [lis_pkg::VALUE_WIDTH-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [lis_pkg::VALUE_WIDTH-1:0] VALUE_MAX = 32'sh7fff_ffff;

  // Shapes of random sequences.
  typedef enum int {
    PAT_WIDE,      // any 32-bit value
    PAT_NARROW,    // a few small values, many repeats
    PAT_RISING,    // mostly increasing, with occasional dips
    PAT_FALLING,   // strictly decreasing
    PAT_EDGES,     // values at the ends of the signed range and around zero
    PAT_COUNT
  } pattern_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  // Stall rates in percent for the sending and the receiving side.
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  // Predicted tail table and counters of the current sequence.
  logic signed [lis_pkg::VALUE_WIDTH-1:0] tail_min [lis_pkg::DEPTH];
  int seq_length = 0;
  int seq_items  = 0;

  lis_pkg::result_t expected_results[$];
  lis_pkg::result_t oldest_expected;

  int error_count     = 0;
  int results_checked = 0;
  int sequences_seen  = 0;
  int overflows_seen  = 0;
  int longest_seen    = 0;

  lis_length_tracker_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // Run limit, far above the slowest legal run.
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Patience-sort step: append a value above every tail, otherwise replace
  // the first tail that is not below it. A sequence that already holds DEPTH
  // items leaves the state alone and flags overflow. The result shows the
  // state before a closing item clears it.
  function automatic lis_pkg::result_t predict_lis_step(
    input logic signed [lis_pkg::VALUE_WIDTH-1:0] v,
    input logic last);
    lis_pkg::result_t r;
    int lo;
    int hi;
    int mid;
    logic over;
    over = (seq_items >= lis_pkg::DEPTH);
    if (!over) begin
      if (seq_length == 0 || tail_min[seq_length-1] < v) begin
        tail_min[seq_length] = v;
        seq_length++;
      end else begin
        lo = 0;
        hi = seq_length - 1;
        while (lo < hi) begin
          mid = (lo + hi) / 2;
          if (tail_min[mid] >= v) begin
            hi = mid;
          end else begin
            lo = mid + 1;
          end
        end
        tail_min[lo] = v;
      end
      seq_items++;
    end
    r.lis_length   = seq_length[lis_pkg::OUT_W-1:0];
    r.change_count = lis_pkg::OUT_W'(seq_items - seq_length);
    r.sequence_end = last;
    r.overflow     = over;
    if (last) begin
      seq_length = 0;
      seq_items  = 0;
    end
    return r;
  endfunction

  // Offers one value, with random idle cycles before it, and records the
  // prediction once the transaction is taken.
  task automatic send_value(input logic signed [lis_pkg::VALUE_WIDTH-1:0] v,
                            input logic last);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_results.push_back(predict_lis_step(v, last));
  endtask

  // Holds off the input until every predicted result has come back.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Receiver side: tready drops at random with the current stall rate.
  always @(posedge clk) begin
    m_axis_tready <= (snk_idle_pct == 0) || ($urandom_range(99) >= snk_idle_pct);
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Every result transaction is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: tdata %h, tlast %b, tuser %b",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
        error_count++;
      end else begin
        oldest_expected = expected_results.pop_front();
        check_field("lis_length", int'(oldest_expected.lis_length),
                    int'(m_axis_tdata[10:0]));
        check_field("change_count", int'(oldest_expected.change_count),
                    int'(m_axis_tdata[21:11]));
        check_field("sequence_end", int'(oldest_expected.sequence_end),
                    int'(m_axis_tlast));
        check_field("overflow", int'(oldest_expected.overflow), int'(m_axis_tuser));
        results_checked++;
        if (m_axis_tlast) sequences_seen++;
        if (m_axis_tuser) overflows_seen++;
        if (int'(m_axis_tdata[10:0]) > longest_seen) longest_seen = int'(m_axis_tdata[10:0]);
      end
    end
  end

  // Range ends, equal values hitting a kept tail, a one-item sequence and
  // purely falling and rising runs.
  task automatic test_directed_extremes();
    send_value(VALUE_MIN, 1'b1);
    send_value(VALUE_MAX, 1'b0);
    send_value(VALUE_MIN, 1'b0);
    send_value(VALUE_MAX, 1'b0);
    send_value(VALUE_MIN, 1'b0);
    send_value(32'sd0, 1'b0);
    send_value(32'sd0, 1'b0);
    send_value(-32'sd1, 1'b0);
    send_value(32'sd1, 1'b0);
    send_value(32'sh5555_5555, 1'b0);
    send_value(32'shAAAA_AAAA, 1'b0);
    send_value(VALUE_MAX, 1'b1);
    for (int k = 5; k >= 1; k--) send_value(k, k == 1);
    for (int k = 1; k <= 6; k++) send_value(k, k == 6);
    wait_for_results();
  endtask

  // A full-depth sequence of mostly rising values with random values mixed
  // in for deep searches, then items past DEPTH that overflow, the closing
  // one included.
  task automatic test_overflow();
    logic signed [lis_pkg::VALUE_WIDTH-1:0] v;
    for (int i = 0; i < lis_pkg::DEPTH; i++) begin
      if (i % 8 == 7) begin
        v = $urandom;
      end else begin
        // Top bits rise with i, so these values strictly increase.
        v = {i[lis_pkg::ADDR_W-1:0],
             (lis_pkg::VALUE_WIDTH-lis_pkg::ADDR_W)'($urandom)} ^ VALUE_MIN;
      end
      send_value(v, 1'b0);
    end
    send_value($urandom, 1'b0);
    send_value($urandom, 1'b0);
    send_value($urandom, 1'b1);
    wait_for_results();
  endtask

  // Short bursts with the input held back until all results are in.
  task automatic test_pause_for_results();
    for (int burst = 0; burst < 4; burst++) begin
      for (int k = 0; k < 3; k++) send_value($urandom, 1'b0);
      wait_for_results();
      for (int k = 0; k < 2; k++) send_value($urandom, k == 1);
      wait_for_results();
    end
  endtask

  // Random sequences of random shape, mostly short, some long.
  task automatic test_random_sequences(input int item_target);
    int sent;
    int run_len;
    pattern_t pattern;
    logic signed [lis_pkg::VALUE_WIDTH-1:0] cur;
    sent = 0;
    while (sent < item_target) begin
      run_len = ($urandom_range(9) == 0) ? $urandom_range(200, 60) : $urandom_range(24, 1);
      pattern = pattern_t'($urandom_range(PAT_COUNT - 1));
      cur = $urandom;
      for (int k = 0; k < run_len; k++) begin
        case (pattern)
          PAT_WIDE: begin
            cur = $urandom;
          end
          PAT_NARROW: begin
            cur = 32'($urandom_range(8)) - 32'sd4;
          end
          PAT_RISING: begin
            if ($urandom_range(7) == 0) cur = cur - 32'($urandom_range(20000));
            else cur = cur + 32'($urandom_range(5000, 1));
          end
          PAT_FALLING: begin
            cur = cur - 32'($urandom_range(5000, 1));
          end
          default: begin
            case ($urandom_range(5))
              0: cur = VALUE_MIN;
              1: cur = VALUE_MIN + 32'sd1;
              2: cur = -32'sd1;
              3: cur = 32'sd0;
              4: cur = VALUE_MAX - 32'sd1;
              default: cur = VALUE_MAX;
            endcase
          end
        endcase
        send_value(cur, k == run_len - 1);
      end
      sent += run_len;
    end
  endtask

  initial begin
    // Slow sender, busy receiver for the directed part.
    src_idle_pct = 11;
    snk_idle_pct = 48;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_overflow();

    // Roles swapped.
    src_idle_pct = 48;
    snk_idle_pct = 11;
    test_pause_for_results();
    test_random_sequences(40);

    // Full rate on both sides.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_sequences(40);

    wait_for_results();
    repeat (30) @(posedge clk);

    $display("Checked %0d results in %0d sequences, %0d overflowed items, longest run %0d.",
             results_checked, sequences_seen, overflows_seen, longest_seen);
    $display("Stall mixes: sender 11%%/receiver 48%%, then 48%%/11%%, then none.");
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/lis_pkg.sv
src/lis_tail_ram.sv
src/lis_search.sv
src/lis_length_tracker_core.sv
verif/testbench.sv
